>>> design/cpv_pkg.sv
// Shared types, constants and the bytewise CRC-32 step for the packet validator.
// Used by every module of the validator; depends on nothing.
package cpv_pkg;

    localparam int unsigned MAX_DATA    = 4;
    localparam int unsigned STORE_DEPTH = 4;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [7:0]  DIGIT_ZERO = 8'h30;
    localparam logic [7:0]  DIGIT_MAX  = DIGIT_ZERO + 8'(MAX_DATA);

    // Reset values of the configuration registers
    localparam logic [7:0] HEADER_RESET  = 8'h5A;
    localparam logic [7:0] COMMAND_RESET = 8'h30;
    localparam logic [7:0] END_RESET     = 8'hB2;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER  = 2'd0;
    localparam logic [1:0] CFG_COMMAND = 2'd1;
    localparam logic [1:0] CFG_END     = 2'd2;

    // Result status codes; ST_OK also means "no error yet" in the line state
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HEADER  = 3'd1,
        ST_COMMAND = 3'd2,
        ST_LENGTH  = 3'd3,
        ST_END     = 3'd4,
        ST_CRC     = 3'd5,
        ST_TRUNC   = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_line;
    } rx_item_t;

    typedef struct packed {
        status_t                        status;
        logic [2:0]                     data_count;
        logic [STORE_DEPTH-1:0][7:0]    data;
    } result_t;

    // One byte through the reflected CRC-32, unrolled into XOR logic
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> design/cpv_in_stage.sv
// Input register of the packet validator: holds one received item.
// Depends on cpv_pkg for the item type.
module cpv_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  cpv_pkg::rx_item_t item_in,
    input  logic              advance,
    output logic              valid,
    output cpv_pkg::rx_item_t item
);
    import cpv_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rx_item_t item_reg;

    // Occupancy: fill on accept, empty when the item moves on
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

>>> design/cpv_line_check.sv
// Line state of the packet validator: field checks, CRC, payload capture and
// the result of the line. Depends on cpv_pkg.
module cpv_line_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  cpv_pkg::rx_item_t item,
    input  logic [7:0]        header_byte,
    input  logic [7:0]        command_byte,
    input  logic [7:0]        end_byte,
    output cpv_pkg::result_t  result
);
    import cpv_pkg::*;

    logic [3:0]                  pos_reg, pos_next;
    logic [2:0]                  len_reg, len_next;
    logic [STORE_DEPTH-1:0][7:0] store_reg, store_next;
    logic [31:0]                 crc_reg, crc_next;
    logic [31:0]                 rcrc_reg, rcrc_next;
    status_t                     err_reg, err_next;

    logic [3:0] end_pos;
    logic [3:0] crc_lim;
    logic [3:0] end_mark;
    logic [3:0] end_pos_next;
    logic [3:0] pos_minus3;
    logic [3:0] crc_off;
    logic [3:0] seen;
    logic [7:0] digit;
    logic       active;
    logic [7:0] b;

    assign b          = item.rx_byte;
    assign end_pos    = {1'b0, len_reg} + 4'd8;
    assign crc_lim    = {1'b0, len_reg} + 4'd4;
    assign end_mark   = {1'b0, len_reg} + 4'd3;
    assign pos_minus3 = pos_reg - 4'd3;
    assign crc_off    = pos_reg - crc_lim;
    assign digit      = b - DIGIT_ZERO;
    assign active     = (err_reg == ST_OK) && (pos_reg < end_pos);

    // Take one byte: position decides which check or capture applies
    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        store_next = store_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        err_next   = err_reg;
        if (active)
        begin
            if (pos_reg < crc_lim)
            begin
                crc_next = crc32_byte(crc_reg, b);
            end
            priority if (pos_reg == 4'd0)
            begin
                if (b != header_byte)
                begin
                    err_next = ST_HEADER;
                end
            end
            else if (pos_reg == 4'd1)
            begin
                if (b != command_byte)
                begin
                    err_next = ST_COMMAND;
                end
            end
            else if (pos_reg == 4'd2)
            begin
                if (b < DIGIT_ZERO || b > DIGIT_MAX)
                begin
                    err_next = ST_LENGTH;
                end
                else
                begin
                    len_next = digit[2:0];
                end
            end
            else if (pos_reg < end_mark)
            begin
                store_next[pos_minus3[1:0]] = b;
            end
            else if (pos_reg == end_mark)
            begin
                if (b != end_byte)
                begin
                    err_next = ST_END;
                end
            end
            else
            begin
                // Received CRC, little-endian
                rcrc_next[{crc_off[1:0], 3'b000} +: 8] = b;
            end
            if (err_next == ST_OK)
            begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    // Result of the line, from the state after this byte
    assign end_pos_next = {1'b0, len_next} + 4'd8;
    assign seen         = pos_next - 4'd3;

    always_comb
    begin
        priority if (err_next != ST_OK)
        begin
            result.status = err_next;
        end
        else if (pos_next < end_pos_next)
        begin
            result.status = ST_TRUNC;
        end
        else if ((crc_next ^ CRC_INIT) != rcrc_next)
        begin
            result.status = ST_CRC;
        end
        else
        begin
            result.status = ST_OK;
        end

        priority if (pos_next <= 4'd3)
        begin
            result.data_count = 3'd0;
        end
        else if (seen > {1'b0, len_next})
        begin
            result.data_count = len_next;
        end
        else
        begin
            result.data_count = seen[2:0];
        end

        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            result.data[i] = (3'(i) < result.data_count) ? store_next[i] : 8'd0;
        end
    end

    // State registers; end of line restores the line to its start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            len_reg   <= 3'd0;
            store_reg <= '0;
            crc_reg   <= CRC_INIT;
            rcrc_reg  <= 32'd0;
            err_reg   <= ST_OK;
        end
        else if (step)
        begin
            if (item.end_of_line)
            begin
                pos_reg   <= 4'd0;
                len_reg   <= 3'd0;
                store_reg <= '0;
                crc_reg   <= CRC_INIT;
                rcrc_reg  <= 32'd0;
                err_reg   <= ST_OK;
            end
            else
            begin
                pos_reg   <= pos_next;
                len_reg   <= len_next;
                store_reg <= store_next;
                crc_reg   <= crc_next;
                rcrc_reg  <= rcrc_next;
                err_reg   <= err_next;
            end
        end
    end

    // Position saturates at the packet end
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= end_pos)
        else $error("byte position beyond packet end");

    // A finished line leaves a clean state
    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.end_of_line |=> pos_reg == 4'd0 && err_reg == ST_OK && crc_reg == CRC_INIT)
        else $error("line state not cleared after end of line");

    // After a failure the position freezes until the line ends
    a_err_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_OK && !(step && item.end_of_line) |=> $stable(pos_reg))
        else $error("position moved after a failed check");

endmodule

>>> design/cpv_out_stage.sv
// Result register of the packet validator: holds one result until taken.
// Depends on cpv_pkg for the result type.
module cpv_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  cpv_pkg::result_t result_in,
    input  logic             stall,
    output logic             valid,
    output cpv_pkg::result_t result
);
    import cpv_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Full on load, empty once the receiver takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

>>> design/crc32_packet_validator_top.sv
// Top level of the CRC-32 framed packet validator.
// Depends on cpv_pkg, cpv_in_stage, cpv_line_check and cpv_out_stage.
//
// Usage:
//   Receive channel (rx_valid/rx_stall): one item per received byte, with
//   end_of_line high on the last byte of the line. Result channel
//   (res_valid/res_stall): one item per line, carrying status, data_count
//   and up to four payload bytes. An item moves on a clock edge where valid
//   is high and stall is low.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): writes the
//   header, command and end bytes; cfg_ready is always high. Write only
//   while no line is in progress.
//   The end-of-line item waits in the input register; its result is then
//   loaded into the result register. Throughput: one byte per cycle unless
//   rx is stalled; a byte's CRC update is XOR logic in the line stage.
//   Stall: while a result waits, bytes that produce no result keep flowing;
//   an end-of-line byte waits in the input register, which then stalls rx.
//   Reset: config registers return to 0x5A/0x30/0xB2 and the line state is
//   empty; both channels come up idle.
module crc32_packet_validator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       end_of_line,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [2:0] status,
    output logic [2:0] data_count,
    output logic [7:0] data_0,
    output logic [7:0] data_1,
    output logic [7:0] data_2,
    output logic [7:0] data_3,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import cpv_pkg::*;

    logic [7:0] header_reg;
    logic [7:0] command_reg;
    logic [7:0] end_reg;

    rx_item_t   rx_item;
    rx_item_t   s1_item;
    logic       s1_valid;
    logic       rx_accept;
    logic       advance;
    logic       res_load;
    result_t    line_result;
    result_t    res_result;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_RESET;
            command_reg <= COMMAND_RESET;
            end_reg     <= END_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HEADER:  header_reg  <= cfg_data;
                CFG_COMMAND: command_reg <= cfg_data;
                CFG_END:     end_reg     <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Flow control: only an end-of-line item needs room in the result register
    assign advance   = s1_valid && (!s1_item.end_of_line || !res_valid || !res_stall);
    assign rx_stall  = s1_valid && !advance;
    assign rx_accept = rx_valid && !rx_stall;
    assign res_load  = advance && s1_item.end_of_line;

    assign rx_item.rx_byte     = rx_byte;
    assign rx_item.end_of_line = end_of_line;

    cpv_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (rx_accept),
        .item_in (rx_item),
        .advance (advance),
        .valid   (s1_valid),
        .item    (s1_item)
    );

    cpv_line_check u_line_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (s1_item),
        .header_byte  (header_reg),
        .command_byte (command_reg),
        .end_byte     (end_reg),
        .result       (line_result)
    );

    cpv_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .result_in (line_result),
        .stall     (res_stall),
        .valid     (res_valid),
        .result    (res_result)
    );

    // Result fields
    assign status     = res_result.status;
    assign data_count = res_result.data_count;
    assign data_0     = res_result.data[0];
    assign data_1     = res_result.data[1];
    assign data_2     = res_result.data[2];
    assign data_3     = res_result.data[3];

    // A waiting result is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_load && res_valid && res_stall))
        else $error("result overwritten while stalled");

    // Receive stall only comes from a held item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> s1_valid && s1_item.end_of_line && res_valid && res_stall)
        else $error("rx stalled without a blocked end-of-line item");

    // A finished line shows up as a result next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> res_valid)
        else $error("line result not presented");

endmodule
